/* rtl/ffca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ffca_pkg;

    localparam int MAX_CHUNKS      = 64;
    localparam int MIN_SPLIT_BYTES = 16;
    localparam int ALIGN_BYTES     = 4;
    localparam int ADDR_W          = $clog2(MAX_CHUNKS);
    localparam int CNT_W           = $clog2(MAX_CHUNKS + 1);
    localparam logic [31:0] POOL_RESET = 32'd65536;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_CLEAR = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] request_size;
        logic [31:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_offset;
        logic [31:0] granted_size;
    } t_result;

    typedef struct packed {
        logic        used;
        logic [31:0] len;
        logic [31:0] off;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        t_addr  raddr;
    } t_tbl_req;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_SH_RD,
        S_SH_WR,
        S_A_TAIL,
        S_A_HEAD,
        S_F_RD,
        S_F_CHK,
        S_M_RD,
        S_M_CHK
    } t_state;

endpackage
`default_nettype wire

/* rtl/first_fit_chunk_allocator_core.sv */
// Clear, an unused kind and an oversize alloc are answered straight from idle. Alloc scans the
// entries, then grants a whole chunk or, on a split, moves the entries above the hit up one slot.
// Free scans the entries, then runs a merge pass over all entries of the table.
// One request at a time: busy is high while the table sequencer runs; results
// are strobed for one cycle. Synchronous active-low reset; after reset the
// init state writes the single free chunk of 65536 bytes.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_chunk_allocator_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  ffca_pkg::t_req     i_req,
    output logic               o_result_valid,
    output ffca_pkg::t_result  o_result,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [31:0]        i_cfg_data
);
    import ffca_pkg::*;

    logic [31:0] r_pool_size;
    t_tbl_req    w_tbl;
    t_entry      w_rdata;
    logic        w_busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= POOL_RESET;
        end else if (i_cfg_valid) begin
            r_pool_size <= i_cfg_data;
        end
    end

    ffca_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_req          (i_req),
        .i_pool_size    (r_pool_size),
        .i_rdata        (w_rdata),
        .o_tbl          (w_tbl),
        .o_busy         (w_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    ffca_table u_table (
        .i_clk   (i_clk),
        .i_tbl   (w_tbl),
        .o_rdata (w_rdata)
    );

    assign busy = w_busy;

endmodule
`default_nettype wire

/* rtl/ffca_table.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffca_table (
    input  wire                i_clk,
    input  ffca_pkg::t_tbl_req i_tbl,
    output ffca_pkg::t_entry   o_rdata
);
    import ffca_pkg::*;

    t_entry r_mem [MAX_CHUNKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_tbl.we) begin
            r_mem[i_tbl.waddr] <= i_tbl.wdata;
        end
        r_rdata <= r_mem[i_tbl.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/ffca_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffca_seq (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  ffca_pkg::t_req     i_req,
    input  wire  [31:0]        i_pool_size,
    input  ffca_pkg::t_entry   i_rdata,
    output ffca_pkg::t_tbl_req o_tbl,
    output logic               o_busy,
    output logic               o_result_valid,
    output ffca_pkg::t_result  o_result
);
    import ffca_pkg::*;

    t_state      r_state, n_state;
    t_cnt        r_idx, n_idx;
    t_cnt        r_wr, n_wr;
    t_cnt        r_cnt, n_cnt;
    t_entry      r_acc, n_acc;
    t_entry      r_hit, n_hit;
    t_addr       r_hit_idx, n_hit_idx;
    logic [31:0] r_size, n_size;
    logic [31:0] r_foff, n_foff;
    logic        r_valid, n_valid;
    t_result     r_res, n_res;

    logic [32:0] w_need;
    logic [31:0] w_rest;
    t_cnt        w_hit_next;

    assign w_need = ({1'b0, i_req.request_size} + 33'(ALIGN_BYTES - 1))
                    & ~33'(ALIGN_BYTES - 1);
    assign w_rest = i_rdata.len - r_size;
    assign w_hit_next = t_cnt'(r_hit_idx) + t_cnt'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= t_cnt'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_wr      <= n_wr;
        r_acc     <= n_acc;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_size    <= n_size;
        r_foff    <= n_foff;
        r_res     <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_size    = r_size;
        n_foff    = r_foff;
        n_valid   = 1'b0;
        n_res     = r_res;
        o_tbl     = '0;
        o_tbl.raddr = r_idx[ADDR_W-1:0];

        case (r_state)
            S_INIT: begin
                o_tbl.we    = 1'b1;
                o_tbl.wdata = '{used: 1'b0, len: POOL_RESET, off: 32'd0};
                n_cnt       = t_cnt'(1);
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_idx   = '0;
                    n_valid = 1'b1;
                    n_res   = '{status: ST_OK, granted_offset: 32'd0, granted_size: 32'd0};
                    case (t_kind'(i_req.kind))
                        K_ALLOC: begin
                            if (w_need[32]) begin
                                n_res.status = ST_OOM;
                            end else begin
                                n_valid = 1'b0;
                                n_size  = w_need[31:0];
                                n_state = S_A_RD;
                            end
                        end
                        K_FREE: begin
                            n_valid = 1'b0;
                            n_foff  = i_req.free_offset;
                            n_state = S_F_RD;
                        end
                        K_CLEAR: begin
                            o_tbl.we    = 1'b1;
                            o_tbl.wdata = '{used: 1'b0, len: i_pool_size, off: 32'd0};
                            n_cnt       = t_cnt'(1);
                        end
                        default: ;
                    endcase
                end
            end
            S_A_RD: begin
                if (r_idx == r_cnt) begin
                    n_valid = 1'b1;
                    n_res   = '{status: ST_OOM, granted_offset: 32'd0, granted_size: 32'd0};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (!i_rdata.used && i_rdata.len >= r_size) begin
                    n_hit     = i_rdata;
                    n_hit_idx = r_idx[ADDR_W-1:0];
                    if (w_rest >= 32'(MIN_SPLIT_BYTES) && r_cnt < t_cnt'(MAX_CHUNKS)) begin
                        n_idx   = r_cnt;
                        n_state = S_SH_RD;
                    end else begin
                        o_tbl.we    = 1'b1;
                        o_tbl.waddr = r_idx[ADDR_W-1:0];
                        o_tbl.wdata = '{used: 1'b1, len: i_rdata.len, off: i_rdata.off};
                        n_valid     = 1'b1;
                        n_res       = '{status: ST_OK, granted_offset: i_rdata.off,
                                        granted_size: i_rdata.len};
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx   = r_idx + t_cnt'(1);
                    n_state = S_A_RD;
                end
            end
            // open a slot at hit+1 by moving the tail up one entry at a time
            S_SH_RD: begin
                if (r_idx > w_hit_next) begin
                    o_tbl.raddr = ADDR_W'(r_idx - t_cnt'(1));
                    n_state     = S_SH_WR;
                end else begin
                    n_state = S_A_TAIL;
                end
            end
            S_SH_WR: begin
                o_tbl.we    = 1'b1;
                o_tbl.waddr = r_idx[ADDR_W-1:0];
                o_tbl.wdata = i_rdata;
                n_idx       = r_idx - t_cnt'(1);
                n_state     = S_SH_RD;
            end
            S_A_TAIL: begin
                o_tbl.we    = 1'b1;
                o_tbl.waddr = w_hit_next[ADDR_W-1:0];
                o_tbl.wdata = '{used: 1'b0, len: r_hit.len - r_size, off: r_hit.off + r_size};
                n_state     = S_A_HEAD;
            end
            S_A_HEAD: begin
                o_tbl.we    = 1'b1;
                o_tbl.waddr = r_hit_idx;
                o_tbl.wdata = '{used: 1'b1, len: r_size, off: r_hit.off};
                n_cnt       = r_cnt + t_cnt'(1);
                n_valid     = 1'b1;
                n_res       = '{status: ST_OK, granted_offset: r_hit.off, granted_size: r_size};
                n_state     = S_IDLE;
            end
            S_F_RD: begin
                if (r_idx == r_cnt) begin
                    n_valid = 1'b1;
                    n_res   = '{status: ST_NOT_ALLOC, granted_offset: 32'd0,
                                granted_size: 32'd0};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_rdata.used && i_rdata.off == r_foff) begin
                    o_tbl.we    = 1'b1;
                    o_tbl.waddr = r_idx[ADDR_W-1:0];
                    o_tbl.wdata = '{used: 1'b0, len: i_rdata.len, off: i_rdata.off};
                    n_idx       = '0;
                    n_wr        = '0;
                    n_state     = S_M_RD;
                end else begin
                    n_idx   = r_idx + t_cnt'(1);
                    n_state = S_F_RD;
                end
            end
            // compaction: r_acc holds entry r_wr-1, flushed when a new run starts and at the end
            S_M_RD: begin
                if (r_idx == r_cnt) begin
                    o_tbl.we    = 1'b1;
                    o_tbl.waddr = ADDR_W'(r_wr - t_cnt'(1));
                    o_tbl.wdata = r_acc;
                    n_cnt       = r_wr;
                    n_valid     = 1'b1;
                    n_res       = '{status: ST_OK, granted_offset: 32'd0, granted_size: 32'd0};
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (r_wr == '0) begin
                    n_acc = i_rdata;
                    n_wr  = t_cnt'(1);
                end else if (!r_acc.used && !i_rdata.used) begin
                    n_acc.len = r_acc.len + i_rdata.len;
                end else begin
                    o_tbl.we    = 1'b1;
                    o_tbl.waddr = ADDR_W'(r_wr - t_cnt'(1));
                    o_tbl.wdata = r_acc;
                    n_acc       = i_rdata;
                    n_wr        = r_wr + t_cnt'(1);
                end
                n_idx   = r_idx + t_cnt'(1);
                n_state = S_M_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_res;

endmodule
`default_nettype wire

/* rtl/ffca_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffca_sva (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                start,
    input wire                busy,
    input ffca_pkg::t_req     i_req,
    input wire                o_result_valid,
    input ffca_pkg::t_result  o_result
);
    import ffca_pkg::*;

    // a result follows either a busy stretch or a request taken the cycle before
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) || $past(start))) else $error("result without a request");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy) else $error("result while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != ST_OK) |->
        (o_result.granted_offset == 32'd0 && o_result.granted_size == 32'd0))
        else $error("error result carries a grant");

    a_clear_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.kind == K_CLEAR) |=>
        (o_result_valid && o_result.status == ST_OK)) else $error("clear not answered");

    a_alloc_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == ST_OK && o_result.granted_size != 32'd0
         && o_result.granted_size[1:0] != 2'd0) |-> $past(busy))
        else $error("odd grant size without a scan");

endmodule

bind first_fit_chunk_allocator_core ffca_sva u_ffca_sva (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_req          (i_req),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
`default_nettype wire
